### src/b32e_pkg.sv
// ----------------------------------------------------------------------------
// b32e_pkg
// Shared types, constants and helper functions of the base32 stream encoder.
// ----------------------------------------------------------------------------
package b32e_pkg;

    // group geometry
    localparam int unsigned GROUP_BYTES = 5;
    localparam int unsigned HELD_DEPTH  = GROUP_BYTES - 1;
    localparam int unsigned GROUP_CHARS = 8;
    localparam int unsigned SLOT_W      = 5;
    localparam int unsigned GROUP_W     = GROUP_BYTES * 8;
    localparam int unsigned COUNT_W     = $clog2(GROUP_BYTES + 1);
    localparam int unsigned IDX_W       = $clog2(GROUP_CHARS);
    localparam int unsigned USED_W      = $clog2(GROUP_CHARS + 1);

    // character codes
    localparam logic [6:0] PAD_CODE   = 7'd61;
    localparam logic [6:0] LOWER_BASE = 7'd97;
    localparam logic [6:0] DIGIT_BASE = 7'd24;
    localparam logic [4:0] LETTERS    = 5'd26;

    localparam logic [IDX_W-1:0]   LAST_IDX  = IDX_W'(GROUP_CHARS - 1);
    localparam logic [COUNT_W-1:0] FULL_HELD = COUNT_W'(HELD_DEPTH);

    typedef logic [7:0]          t_byte;
    typedef logic [6:0]          t_char;
    typedef logic [SLOT_W-1:0]   t_slot;
    typedef logic [COUNT_W-1:0]  t_count;
    typedef logic [IDX_W-1:0]    t_idx;
    typedef logic [USED_W-1:0]   t_used;

    // closed group handed from the gatherer to the emitter
    typedef struct packed {
        logic                  valid;
        logic [GROUP_W-1:0]    bits;
        t_used                 used;
    } t_group;

    // base32 alphabet: a-z then 2-7
    function automatic t_char b32_char(input t_slot v);
        t_char c;
        if (v < LETTERS) begin
            c = LOWER_BASE + {2'b00, v};
        end else begin
            c = DIGIT_BASE + {2'b00, v};
        end
        return c;
    endfunction

    // data characters carried by a group of n bytes
    function automatic t_used data_chars(input t_count n);
        t_used u;
        case (n)
            3'd1:    u = 4'd2;
            3'd2:    u = 4'd4;
            3'd3:    u = 4'd5;
            3'd4:    u = 4'd7;
            3'd5:    u = 4'd8;
            default: u = 4'd0;
        endcase
        return u;
    endfunction

endpackage

### src/b32e_byte_if.sv
// ----------------------------------------------------------------------------
// b32e_byte_if
// Byte stream channel: valid/ready handshake with a byte and an end flag.
// ----------------------------------------------------------------------------
interface b32e_byte_if;
    logic            valid;
    logic            ready;
    b32e_pkg::t_byte data_byte;
    logic            last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

### src/b32e_char_if.sv
// ----------------------------------------------------------------------------
// b32e_char_if
// Character stream channel: valid/ready handshake with an ASCII code and a
// group end mark.
// ----------------------------------------------------------------------------
interface b32e_char_if;
    logic            valid;
    logic            ready;
    b32e_pkg::t_char char_code;
    logic            group_end;

    modport source (output valid, output char_code, output group_end, input ready);
    modport sink   (input valid, input char_code, input group_end, output ready);
endinterface

### src/b32e_gather.sv
// ----------------------------------------------------------------------------
// b32e_gather
// Holds up to four bytes and closes a group on the fifth byte or a last byte.
// ----------------------------------------------------------------------------
module b32e_gather (
    input  logic                i_clk,
    input  logic                i_rst_n,
    b32e_byte_if.sink           i_byte,
    input  logic                i_grp_ready,
    output b32e_pkg::t_group    o_grp
);
    import b32e_pkg::*;

    t_byte  r_held [HELD_DEPTH];
    t_count r_count;
    t_count n_count;
    t_byte  w_grp_bytes [GROUP_BYTES];
    logic   w_closing;
    logic   w_accept;

    // a byte closes the group when flagged last or when four are held
    assign w_closing    = i_byte.last_byte || (r_count == FULL_HELD);
    assign i_byte.ready = !w_closing || i_grp_ready;
    assign w_accept     = i_byte.valid && i_byte.ready;

    // assemble the group: held bytes, then the new byte, then zero fill
    always_comb begin
        for (int i = 0; i < GROUP_BYTES; i++) begin
            if (i < HELD_DEPTH && COUNT_W'(i) < r_count) begin
                w_grp_bytes[i] = r_held[$clog2(HELD_DEPTH)'(i)];
            end else if (COUNT_W'(i) == r_count) begin
                w_grp_bytes[i] = i_byte.data_byte;
            end else begin
                w_grp_bytes[i] = '0;
            end
        end
    end

    always_comb begin
        o_grp.valid = i_byte.valid && w_closing;
        for (int i = 0; i < GROUP_BYTES; i++) begin
            o_grp.bits[GROUP_W - 8 - 8 * i +: 8] = w_grp_bytes[i];
        end
        o_grp.used = data_chars(r_count + COUNT_W'(1));
    end

    // fill count
    always_comb begin
        n_count = r_count;
        if (w_accept) begin
            n_count = w_closing ? '0 : r_count + COUNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // held bytes, written at the fill position
    always_ff @(posedge i_clk) begin
        if (w_accept && !w_closing) begin
            r_held[r_count[$clog2(HELD_DEPTH)-1:0]] <= i_byte.data_byte;
        end
    end

endmodule

### src/b32e_emit.sv
// ----------------------------------------------------------------------------
// b32e_emit
// Group register and character output register: one base32 character or pad
// per cycle while the output is not stalled, eight per group.
// ----------------------------------------------------------------------------
module b32e_emit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  b32e_pkg::t_group    i_grp,
    output logic                o_grp_ready,
    b32e_char_if.source         o_char
);
    import b32e_pkg::*;

    logic [GROUP_CHARS-1:0][SLOT_W-1:0] r_slots;
    t_used  r_used;
    t_idx   r_idx;
    logic   r_busy;
    t_char  r_char;
    logic   r_end;
    logic   r_ovalid;
    logic   w_adv;
    logic   w_load;
    t_char  n_char;

    // move one character when the output register is free or being taken
    assign w_adv       = r_busy && (!r_ovalid || o_char.ready);
    assign o_grp_ready = !r_busy || (w_adv && r_idx == LAST_IDX);
    assign w_load      = i_grp.valid && o_grp_ready;

    // character of the current slot, first slot in the top bits
    always_comb begin
        if ({1'b0, r_idx} < r_used) begin
            n_char = b32_char(r_slots[LAST_IDX - r_idx]);
        end else begin
            n_char = PAD_CODE;
        end
    end

    // group register and slot index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (w_load) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (w_adv) begin
            r_idx <= r_idx + IDX_W'(1);
            if (r_idx == LAST_IDX) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_slots <= i_grp.bits;
            r_used  <= i_grp.used;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_adv) begin
            r_ovalid <= 1'b1;
        end else if (o_char.ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_char <= n_char;
            r_end  <= (r_idx == LAST_IDX);
        end
    end

    assign o_char.valid     = r_ovalid;
    assign o_char.char_code = r_char;
    assign o_char.group_end = r_end;

endmodule

### src/base32_stream_encoder.sv
// ----------------------------------------------------------------------------
// base32_stream_encoder
// Lowercase base32 encoder for a byte stream: five bytes in, eight characters
// out, short final groups zero-filled and padded with '='.
// ----------------------------------------------------------------------------
//
//   channel   dir   handshake      payload
//   i_byte    in    valid/ready    data_byte[7:0], last_byte
//   o_char    out   valid/ready    char_code[6:0], group_end
//
// Bytes that do not close a group are taken at one per cycle, without waiting.
// A closing byte is taken once the group register is free, at the latest in
// the cycle its eighth character moves into the output register.
// Each group leaves at one character per cycle while the output is not stalled,
// so a steady stream is bound by the single character output register.
// Reset is synchronous, active low, and clears the fill count and valids.
// A stalled output holds its character; input keeps filling up to four held bytes.
module base32_stream_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    b32e_byte_if.sink   i_byte,
    b32e_char_if.source o_char
);
    import b32e_pkg::*;

    t_group w_grp;
    logic   w_grp_ready;

    // byte gathering
    b32e_gather u_gather (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_byte      (i_byte),
        .i_grp_ready (w_grp_ready),
        .o_grp       (w_grp)
    );

    // character emission
    b32e_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_grp       (w_grp),
        .o_grp_ready (w_grp_ready),
        .o_char      (o_char)
    );

endmodule

### dv/tb_base32_stream_encoder.sv
// ----------------------------------------------------------------------------
// tb_base32_stream_encoder
// Self-checking testbench of the base32 stream encoder. A table of directed
// byte transactions (byte extremes, known base32 strings, short groups of
// every size) is followed by random messages of random length.
// Every byte accepted is fed to a behavioural encoder, and each character
// transaction is checked against the oldest expected character. Both sides
// insert random idle bursts; the closing stretch runs at full rate.
// ----------------------------------------------------------------------------
module tb_base32_stream_encoder;
    import b32e_pkg::*;

    localparam int unsigned RANDOM_BYTES = 155;
    localparam int unsigned CALM_BYTES   = 30;
    localparam int unsigned TAIL_CYCLES  = 16;
    localparam int unsigned CYCLE_LIMIT  = 400000;

    // one expected character transaction
    typedef struct {
        t_char code;
        logic  gend;
    } t_char_exp;

    // one directed row; chars is the typed group, or empty to use the encoder
    typedef struct {
        t_byte data;
        logic  lst;
        string chars;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n;

    b32e_byte_if byte_ch ();
    b32e_char_if char_ch ();

    base32_stream_encoder DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (byte_ch),
        .o_char  (char_ch)
    );

    t_char_exp   pending_chars[$];
    t_dir_row    dir_rows[$];
    t_byte       enc_held[4];
    int unsigned enc_fill;
    int unsigned err_cnt;
    int unsigned cycle_cnt;
    int unsigned gap_pct;
    int unsigned stall_pct;
    bit          calm;

    // clock
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // behavioural encoder: takes one byte, returns the characters it closes
    function automatic int unsigned encode_byte(input t_byte b, input logic lst,
                                                output t_char chars[8]);
        logic [39:0] grp;
        int unsigned nbytes;
        int unsigned ndata;
        logic [4:0]  slot;
        for (int k = 0; k < 8; k++) chars[k] = PAD_CODE;
        if (!lst && enc_fill < 4) begin
            enc_held[enc_fill] = b;
            enc_fill++;
            return 0;
        end
        nbytes = enc_fill + 1;
        grp    = '0;
        for (int i = 0; i < 5; i++) begin
            if (i < enc_fill) grp[39 - 8*i -: 8] = enc_held[i];
        end
        grp[39 - 8*enc_fill -: 8] = b;
        // 8 bits per byte, 5 bits per character, rounded up
        ndata = (nbytes * 8 + 4) / 5;
        for (int k = 0; k < 8; k++) begin
            if (k < ndata) begin
                slot = grp[39 - 5*k -: 5];
                if (slot < 26) chars[k] = t_char'("a" + slot);
                else           chars[k] = t_char'("2" + slot - 26);
            end
        end
        enc_fill = 0;
        return 8;
    endfunction

    // accepted byte: queue what the encoder (or the typed row) says follows
    task automatic note_byte(input t_byte b, input logic lst, input string typed);
        t_char       chars[8];
        int unsigned n;
        n = encode_byte(b, lst, chars);
        for (int k = 0; k < n; k++) begin
            t_char_exp e;
            e.code = (typed.len() == 8) ? t_char'(typed[k]) : chars[k];
            e.gend = (k == 7);
            pending_chars.push_back(e);
        end
    endtask

    // drive one byte transaction and hold it until taken
    task automatic send_byte(input t_byte b, input logic lst, input string typed);
        byte_ch.valid     <= 1'b1;
        byte_ch.data_byte <= b;
        byte_ch.last_byte <= lst;
        do @(posedge i_clk); while (!byte_ch.ready);
        note_byte(b, lst, typed);
        if (!calm && $urandom_range(0, 99) < gap_pct) begin
            byte_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
    endtask

    task automatic add_row(input t_byte b, input logic lst, input string s);
        t_dir_row r;
        r.data  = b;
        r.lst   = lst;
        r.chars = s;
        dir_rows.push_back(r);
    endtask

    // sink side: random stall bursts
    initial begin
        int unsigned stall_left;
        stall_left    = 0;
        char_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!calm && stall_left == 0 && $urandom_range(0, 99) < stall_pct)
                stall_left = $urandom_range(1, 19);
            if (calm) stall_left = 0;
            if (stall_left != 0) begin
                char_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                char_ch.ready <= 1'b1;
            end
        end
    end

    // character checker
    always @(posedge i_clk) begin
        if (i_rst_n && char_ch.valid && char_ch.ready) begin
            if (pending_chars.size() == 0) begin
                $error("unexpected character transaction: char_code %0d, group_end %0b",
                       char_ch.char_code, char_ch.group_end);
                err_cnt++;
            end else begin
                t_char_exp e;
                e = pending_chars.pop_front();
                if (char_ch.char_code !== e.code) begin
                    $error("char_code mismatch: expected %0d, actual %0d",
                           e.code, char_ch.char_code);
                    err_cnt++;
                end
                if (char_ch.group_end !== e.gend) begin
                    $error("group_end mismatch: expected %0b, actual %0b",
                           e.gend, char_ch.group_end);
                    err_cnt++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // stimulus
    initial begin
        int unsigned sent;
        int unsigned msg_len;
        bit          paused;
        t_byte       b;

        err_cnt   = 0;
        cycle_cnt = 0;
        enc_fill  = 0;
        calm      = 1'b0;
        paused    = 1'b0;
        gap_pct   = 25;
        stall_pct = 20;
        i_rst_n           <= 1'b0;
        byte_ch.valid     <= 1'b0;
        byte_ch.data_byte <= '0;
        byte_ch.last_byte <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // byte extremes as one-byte messages
        add_row(8'h00, 1'b1, "aa======");
        add_row(8'hff, 1'b1, "74======");
        // full group of all ones closed without an end flag
        add_row(8'hff, 1'b0, "");
        add_row(8'hff, 1'b0, "");
        add_row(8'hff, 1'b0, "");
        add_row(8'hff, 1'b0, "");
        add_row(8'hff, 1'b0, "77777777");
        // short groups of one to four bytes, then a full group ended by the flag
        add_row("f", 1'b1, "my======");
        add_row("f", 1'b0, "");
        add_row("o", 1'b1, "mzxq====");
        add_row("f", 1'b0, "");
        add_row("o", 1'b0, "");
        add_row("o", 1'b1, "mzxw6===");
        add_row("f", 1'b0, "");
        add_row("o", 1'b0, "");
        add_row("o", 1'b0, "");
        add_row("b", 1'b1, "mzxw6yq=");
        add_row("f", 1'b0, "");
        add_row("o", 1'b0, "");
        add_row("o", 1'b0, "");
        add_row("b", 1'b0, "");
        add_row("a", 1'b1, "mzxw6ytb");
        // lone high and low bits across byte boundaries
        add_row(8'h80, 1'b0, "");
        add_row(8'h01, 1'b0, "");
        add_row(8'h7f, 1'b1, "");

        foreach (dir_rows[i]) send_byte(dir_rows[i].data, dir_rows[i].lst, dir_rows[i].chars);

        // hold off until every character so far has come out
        byte_ch.valid <= 1'b0;
        while (pending_chars.size() != 0) @(posedge i_clk);
        @(posedge i_clk);

        // random messages, mostly short, some spanning several groups
        sent = 0;
        while (sent < RANDOM_BYTES) begin
            case ($urandom_range(0, 3))
                0:       gap_pct = 0;
                1:       gap_pct = 10;
                2:       gap_pct = 30;
                default: gap_pct = 60;
            endcase
            stall_pct = $urandom_range(0, 3) * 10;
            if ($urandom_range(0, 7) == 0) msg_len = $urandom_range(11, 27);
            else                          msg_len = $urandom_range(1, 10);
            for (int i = 0; i < msg_len; i++) begin
                case ($urandom_range(0, 7))
                    0:       b = 8'h00;
                    1:       b = 8'hff;
                    default: b = t_byte'($urandom_range(0, 255));
                endcase
                send_byte(b, (i == msg_len - 1), "");
                sent++;
                if (sent >= RANDOM_BYTES - CALM_BYTES) calm = 1'b1;
            end
            // a second full drain halfway through
            if (!paused && sent >= RANDOM_BYTES / 2) begin
                paused = 1'b1;
                byte_ch.valid <= 1'b0;
                while (pending_chars.size() != 0) @(posedge i_clk);
                @(posedge i_clk);
            end
        end
        byte_ch.valid <= 1'b0;

        // drain and let any stray character show up
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

### base32_stream_encoder.f
src/b32e_pkg.sv
src/b32e_byte_if.sv
src/b32e_char_if.sv
src/b32e_gather.sv
src/b32e_emit.sv
src/base32_stream_encoder.sv
dv/tb_base32_stream_encoder.sv
